// File: rtl/mpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

  // Message length field width in use; the port itself is 24 bits wide.
  localparam int unsigned MSG_LEN_BITS = 24;
  // Remaining-length sum: 2 + topic + 2 + message is given two bits of headroom.
  localparam int unsigned REM_BITS = ((MSG_LEN_BITS > 16) ? MSG_LEN_BITS : 16) + 2;

  // Output sequence steps, emitted from the lowest index up.
  localparam int unsigned STEP_TYPE = 0;
  localparam int unsigned STEP_REM  = 1;
  localparam int unsigned STEP_FIX0 = 2;
  localparam int unsigned STEP_FIX1 = 3;
  localparam int unsigned STEP_TLH  = 4;
  localparam int unsigned STEP_TLL  = 5;
  localparam int unsigned STEP_DATA = 6;
  localparam int unsigned STEP_IDH  = 7;
  localparam int unsigned STEP_IDL  = 8;
  localparam int unsigned STEP_QOS  = 9;
  localparam int unsigned STEP_ZERO = 10;
  localparam int unsigned NUM_STEPS = 11;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] TYPE_PUB   = 8'h30;
  localparam logic [7:0] TYPE_SUB   = 8'h82;
  localparam logic [7:0] TYPE_UNSUB = 8'hA2;
  localparam logic [7:0] TYPE_PING  = 8'hC0;
  localparam logic [7:0] TYPE_DISC  = 8'hE0;
  localparam logic [7:0] FIXED_IDENT_LSB = 8'h01;

  typedef enum logic [2:0] {
    FUNC_PUB   = 3'd0,
    FUNC_SUB   = 3'd1,
    FUNC_UNSUB = 3'd2,
    FUNC_PING  = 3'd3,
    FUNC_DISC  = 3'd4,
    FUNC_DATA  = 3'd5
  } func_e;

  typedef enum logic [3:0] {
    KIND_IDLE  = 4'b0001,
    KIND_PUB   = 4'b0010,
    KIND_SUB   = 4'b0100,
    KIND_UNSUB = 4'b1000
  } kind_e;

  // One classified transaction: which bytes to emit and their contents.
  typedef struct packed {
    logic [NUM_STEPS-1:0] mask;
    logic [7:0]           type_byte;
    logic [REM_BITS-1:0]  remlen;
    logic [15:0]          topic_len;
    logic [7:0]           data;
    logic [15:0]          ident;
    logic [1:0]           qos;
    logic                 close;
    logic                 err;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } queue_head_t;

endpackage

`default_nettype wire

// File: rtl/mpf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mpf_front
  import mpf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [15:0] topic_len_i,
  input  wire logic [23:0] message_len_i,
  input  wire logic [1:0]  qos_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        queue_full_i,
  output logic             push_o,
  output desc_t            desc_o
);

  kind_e                   kind_q, kind_d;
  logic [15:0]             topic_left_q, topic_left_d;
  logic [MSG_LEN_BITS-1:0] message_left_q, message_left_d;
  logic [1:0]              held_qos_q, held_qos_d;
  logic [15:0]             packet_ident_q, packet_ident_d;
  logic                    accept;
  logic [MSG_LEN_BITS-1:0] mlen;
  func_e                   func;

  assign ready_o = !queue_full_i;
  assign accept  = valid_i && ready_o;
  assign mlen    = message_len_i[MSG_LEN_BITS-1:0];
  assign func    = func_e'(func_i);

  always_comb begin
    kind_d         = kind_q;
    topic_left_d   = topic_left_q;
    message_left_d = message_left_q;
    held_qos_d     = held_qos_q;
    packet_ident_d = packet_ident_q;
    desc_o         = '0;
    push_o         = 1'b0;
    desc_o.topic_len = topic_len_i;
    desc_o.ident     = packet_ident_q;
    desc_o.data      = data_byte_i;
    if (accept) begin
      unique case (func)
        FUNC_PUB: begin
          push_o         = 1'b1;
          held_qos_d     = qos_i;
          topic_left_d   = topic_len_i;
          message_left_d = mlen;
          desc_o.type_byte = TYPE_PUB | {5'b0, qos_i, 1'b0};
          desc_o.remlen = REM_BITS'(2) + REM_BITS'(topic_len_i)
                        + ((qos_i != 2'd0) ? REM_BITS'(2) : REM_BITS'(0))
                        + REM_BITS'(mlen);
          desc_o.mask[STEP_TYPE] = 1'b1;
          desc_o.mask[STEP_REM]  = 1'b1;
          desc_o.mask[STEP_TLH]  = 1'b1;
          desc_o.mask[STEP_TLL]  = 1'b1;
          kind_d = KIND_PUB;
          if (topic_len_i == 16'd0) begin
            if (qos_i != 2'd0) begin
              desc_o.mask[STEP_IDH] = 1'b1;
              desc_o.mask[STEP_IDL] = 1'b1;
              packet_ident_d = packet_ident_q + 16'd1;
            end
            if (mlen == '0) begin
              desc_o.close = 1'b1;
              kind_d       = KIND_IDLE;
            end
          end
        end
        FUNC_SUB, FUNC_UNSUB: begin
          push_o         = 1'b1;
          held_qos_d     = qos_i;
          topic_left_d   = topic_len_i;
          message_left_d = '0;
          desc_o.type_byte = (func == FUNC_SUB) ? TYPE_SUB : TYPE_UNSUB;
          desc_o.remlen = REM_BITS'(4) + REM_BITS'(topic_len_i)
                        + ((func == FUNC_SUB) ? REM_BITS'(1) : REM_BITS'(0));
          desc_o.mask[STEP_TYPE] = 1'b1;
          desc_o.mask[STEP_REM]  = 1'b1;
          desc_o.mask[STEP_FIX0] = 1'b1;
          desc_o.mask[STEP_FIX1] = 1'b1;
          desc_o.mask[STEP_TLH]  = 1'b1;
          desc_o.mask[STEP_TLL]  = 1'b1;
          desc_o.qos = qos_i;
          kind_d = (func == FUNC_SUB) ? KIND_SUB : KIND_UNSUB;
          if (topic_len_i == 16'd0) begin
            desc_o.mask[STEP_QOS] = (func == FUNC_SUB);
            desc_o.close = 1'b1;
            kind_d       = KIND_IDLE;
          end
        end
        FUNC_PING, FUNC_DISC: begin
          push_o         = 1'b1;
          kind_d         = KIND_IDLE;
          topic_left_d   = '0;
          message_left_d = '0;
          desc_o.type_byte = (func == FUNC_PING) ? TYPE_PING : TYPE_DISC;
          desc_o.mask[STEP_TYPE] = 1'b1;
          desc_o.mask[STEP_ZERO] = 1'b1;
          desc_o.close = 1'b1;
        end
        FUNC_DATA: begin
          push_o = 1'b1;
          desc_o.mask[STEP_DATA] = 1'b1;
          desc_o.qos = held_qos_q;
          priority if (kind_q == KIND_IDLE) begin
            // no packet open: flag an error byte
            desc_o.data  = '0;
            desc_o.close = 1'b1;
            desc_o.err   = 1'b1;
          end else if (topic_left_q != 16'd0) begin
            topic_left_d = topic_left_q - 16'd1;
            if (topic_left_q == 16'd1) begin
              // topic complete: append what follows it
              unique case (kind_q)
                KIND_PUB: begin
                  if (held_qos_q != 2'd0) begin
                    desc_o.mask[STEP_IDH] = 1'b1;
                    desc_o.mask[STEP_IDL] = 1'b1;
                    packet_ident_d = packet_ident_q + 16'd1;
                  end
                  if (message_left_q == '0) begin
                    desc_o.close = 1'b1;
                    kind_d       = KIND_IDLE;
                  end
                end
                KIND_SUB: begin
                  desc_o.mask[STEP_QOS] = 1'b1;
                  desc_o.close = 1'b1;
                  kind_d       = KIND_IDLE;
                end
                default: begin
                  desc_o.close = 1'b1;
                  kind_d       = KIND_IDLE;
                end
              endcase
            end
          end else begin
            message_left_d = message_left_q - MSG_LEN_BITS'(1);
            if (message_left_q == MSG_LEN_BITS'(1)) begin
              desc_o.close = 1'b1;
              kind_d       = KIND_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q         <= KIND_IDLE;
      topic_left_q   <= '0;
      message_left_q <= '0;
      held_qos_q     <= '0;
      packet_ident_q <= '0;
    end else begin
      kind_q         <= kind_d;
      topic_left_q   <= topic_left_d;
      message_left_q <= message_left_d;
      held_qos_q     <= held_qos_d;
      packet_ident_q <= packet_ident_d;
    end
  end

`ifndef SYNTH
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (desc_o.mask != '0))
    else $error("front pushed a transaction with no bytes");

  a_ident_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && desc_o.mask[STEP_IDH]) |=> (packet_ident_q == $past(packet_ident_q) + 16'd1))
    else $error("packet identifier did not advance by one");
`endif

endmodule

`default_nettype wire

// File: rtl/mpf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mpf_queue
  import mpf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  desc_t      desc_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output queue_head_t head_o
);

  localparam int unsigned CNT_W = QPTR_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  desc_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o        = (cnt_q == DEPTH_C);
  assign head_o.valid  = (cnt_q != '0);
  assign head_o.desc   = slot_q[rd_ptr_q];
  assign do_push       = push_i && !full_o;
  assign do_pop        = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= DEPTH_C) && (cnt_q[QPTR_W-1:0] == QPTR_W'(wr_ptr_q - rd_ptr_q)))
    else $error("queue count out of step with pointers");
`endif

endmodule

`default_nettype wire

// File: rtl/mpf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mpf_back
  import mpf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  queue_head_t head_i,
  output logic       pop_o,
  output logic       valid_o,
  input  wire logic  ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       error_o
);

  desc_t                work_q, work_d;
  logic [NUM_STEPS-1:0] cur_oh, mask_after;
  logic [REM_BITS-1:0]  rem_hi;
  logic                 rem_more;
  logic                 advance, load;
  logic [7:0]           byte_sel;
  logic                 valid_q, valid_d;
  logic [7:0]           byte_q, byte_d;
  logic                 last_q, last_d;
  logic                 err_q, err_d;

  assign advance  = (work_q.mask != '0) && (!valid_q || ready_i);
  assign cur_oh   = work_q.mask & (~work_q.mask + NUM_STEPS'(1));
  assign rem_hi   = work_q.remlen >> 7;
  assign rem_more = (rem_hi != '0);

  always_comb begin
    mask_after = work_q.mask & ~cur_oh;
    if (cur_oh[STEP_REM] && rem_more) begin
      mask_after[STEP_REM] = 1'b1;
    end
  end

  always_comb begin
    priority if (work_q.mask[STEP_TYPE]) byte_sel = work_q.type_byte;
    else if (work_q.mask[STEP_REM])      byte_sel = {rem_more, work_q.remlen[6:0]};
    else if (work_q.mask[STEP_FIX0])     byte_sel = 8'h00;
    else if (work_q.mask[STEP_FIX1])     byte_sel = FIXED_IDENT_LSB;
    else if (work_q.mask[STEP_TLH])      byte_sel = work_q.topic_len[15:8];
    else if (work_q.mask[STEP_TLL])      byte_sel = work_q.topic_len[7:0];
    else if (work_q.mask[STEP_DATA])     byte_sel = work_q.data;
    else if (work_q.mask[STEP_IDH])      byte_sel = work_q.ident[15:8];
    else if (work_q.mask[STEP_IDL])      byte_sel = work_q.ident[7:0];
    else if (work_q.mask[STEP_QOS])      byte_sel = {6'b0, work_q.qos};
    else                                 byte_sel = 8'h00;
  end

  // Take the next transaction once the current one empties.
  assign load  = head_i.valid && ((work_q.mask == '0) || (advance && (mask_after == '0)));
  assign pop_o = load;

  always_comb begin
    work_d  = work_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    err_d   = err_q;
    if (advance) begin
      valid_d = 1'b1;
      byte_d  = byte_sel;
      last_d  = work_q.close && (mask_after == '0);
      err_d   = work_q.err;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      work_d = head_i.desc;
    end else if (advance) begin
      work_d.mask = mask_after;
      if (cur_oh[STEP_REM]) begin
        work_d.remlen = rem_hi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      work_q  <= work_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign valid_o    = valid_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;
  assign error_o    = err_q;

`ifndef SYNTH
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!error_o || (last_o && (out_byte_o == 8'h00))))
    else $error("error byte not flagged last or not zero");
`endif

endmodule

`default_nettype wire

// File: rtl/mqtt_packet_framer_top.sv
// Throughput: one output byte per cycle while m_axis_tready is high, set by the back-end byte
// sequencer; a data item yields 1 to 3 bytes (identifier or QoS byte after the final topic
// byte), a start item 2 to 9 bytes (one per header byte). A 4-entry queue decouples input
// from byte emission. Each byte passes the queue slot, work_q and then byte_q.
// Reset (rst_ni low, asynchronous) closes any open packet and clears the identifier.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_framer_top
  import mpf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] topic_len, [39:16] message_len, [41:40] qos, [49:42] data_byte, [55:50] zero
  input  wire logic [55:0] s_axis_tdata,
  // [2:0] func
  input  wire logic [2:0]  s_axis_tuser,
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,
  // [0] error
  output logic             m_axis_tuser
);

  logic        queue_full;
  logic        push;
  desc_t       push_desc;
  logic        pop;
  queue_head_t head;

  // Front: accept items, track the open packet, classify into one transaction.
  mpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .func_i       (s_axis_tuser),
    .topic_len_i  (s_axis_tdata[15:0]),
    .message_len_i(s_axis_tdata[39:16]),
    .qos_i        (s_axis_tdata[41:40]),
    .data_byte_i  (s_axis_tdata[49:42]),
    .queue_full_i (queue_full),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  // Queue: hold classified transactions while the back end is busy.
  mpf_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .desc_i(push_desc),
    .full_o(queue_full),
    .pop_i (pop),
    .head_o(head)
  );

  // Back: expand each transaction into bytes through a registered output stage.
  mpf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .out_byte_o(m_axis_tdata),
    .last_o    (m_axis_tlast),
    .error_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire
